// ===== rtl/qeou_pkg.sv =====
// shared types, constants and tables for the quaternion orientation update unit
`default_nettype none
package qeou_pkg;

  // defaults for the top level parameters
  localparam int ANGLE_WIDTH_DEF     = 16;
  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;

  // internal datapath widths
  localparam int ZW        = 36;   // cordic angle and vector, Q.32 with headroom
  localparam int TW        = 23;   // sine and cosine, Q.20
  localparam int DW        = 32;   // delta quaternion components, Q.28
  localparam int AMW       = 46;   // first multiplier operand
  localparam int ANG_FRAC  = 32;
  localparam int TABLE_LEN = 24;
  localparam int QDEPTH    = 2;

  // rounding shifts
  localparam int SC_SHIFT    = 12;  // Q.32 to Q.20
  localparam int DELTA_SHIFT = 32;  // Q.60 to Q.28
  localparam int OUT_SHIFT   = 28;  // Q.28 product back to component format

  localparam logic signed [ZW-1:0] CORDIC_GAIN = 36'sd2608131496;
  localparam logic signed [ZW-1:0] PI_Q32      = 36'sd13493037705;
  localparam logic signed [ZW-1:0] HALF_PI_Q32 = 36'sd6746518852;

  // back end sequencer phases
  typedef enum logic [2:0] {
    P_IDLE,
    P_CORDIC,
    P_ROUND,
    P_PAIR,
    P_TRI0,
    P_TRI1,
    P_DSUM,
    P_OUT
  } phase_t;

  // folded half angles of one transaction
  typedef struct packed {
    logic [2:0][ZW-1:0] z;
    logic [2:0]         flip;
  } fold_t;

  // queue status toward the front and back end
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // atan(2^-i) in Q.32
  function automatic logic signed [ZW-1:0] atan_q32(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 36'sd3373259426;
      5'd1:    v = 36'sd1991351318;
      5'd2:    v = 36'sd1052175346;
      5'd3:    v = 36'sd534100635;
      5'd4:    v = 36'sd268086748;
      5'd5:    v = 36'sd134174063;
      5'd6:    v = 36'sd67103403;
      5'd7:    v = 36'sd33553749;
      5'd8:    v = 36'sd16777131;
      5'd9:    v = 36'sd8388597;
      5'd10:   v = 36'sd4194303;
      5'd11:   v = 36'sd2097152;
      5'd12:   v = 36'sd1048576;
      5'd13:   v = 36'sd524288;
      5'd14:   v = 36'sd262144;
      5'd15:   v = 36'sd131072;
      5'd16:   v = 36'sd65536;
      5'd17:   v = 36'sd32768;
      5'd18:   v = 36'sd16384;
      5'd19:   v = 36'sd8192;
      5'd20:   v = 36'sd4096;
      5'd21:   v = 36'sd2048;
      5'd22:   v = 36'sd1024;
      5'd23:   v = 36'sd512;
      default: v = '0;
    endcase
    return v;
  endfunction

  // subtracted terms of the hamilton product, bit = multiplier lane
  function automatic logic [3:0] neg_mask(input logic [1:0] comp);
    logic [3:0] m;
    case (comp)
      2'd0:    m = 4'b1110;
      2'd1:    m = 4'b1000;
      2'd2:    m = 4'b0010;
      2'd3:    m = 4'b0100;
      default: m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/qeou_front.sv =====
// front end: half angle scaling and range fold of the three input angles
`default_nettype none
module qeou_front #(
  parameter int ANGLE_WIDTH = qeou_pkg::ANGLE_WIDTH_DEF
) (
  input  wire logic [ANGLE_WIDTH-1:0] in_angle_x,
  input  wire logic [ANGLE_WIDTH-1:0] in_angle_y,
  input  wire logic [ANGLE_WIDTH-1:0] in_angle_z,
  output qeou_pkg::fold_t             fold
);
  import qeou_pkg::*;

  localparam int HSHIFT = ANG_FRAC + 2 - ANGLE_WIDTH;

  logic [2:0][ANGLE_WIDTH-1:0] ang;

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  // scale to Q.32 half angle, fold into +-pi/2
  always_comb begin
    logic signed [ZW-1:0] h;
    for (int l = 0; l < 3; l++) begin
      h = ZW'($signed(ang[l])) <<< HSHIFT;
      if (h > HALF_PI_Q32) begin
        fold.z[l]    = h - PI_Q32;
        fold.flip[l] = 1'b1;
      end else if (h < -HALF_PI_Q32) begin
        fold.z[l]    = h + PI_Q32;
        fold.flip[l] = 1'b1;
      end else begin
        fold.z[l]    = h;
        fold.flip[l] = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qeou_queue.sv =====
// short queue of folded transactions between front and back end
`default_nettype none
module qeou_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  qeou_pkg::fold_t      push_data,
  input  wire logic            pop,
  output qeou_pkg::fold_t      pop_data,
  output qeou_pkg::qstat_t     stat
);
  import qeou_pkg::*;

  localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  fold_t           mem [QDEPTH];
  logic [PTRW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign stat.full  = (cnt_r == CNTW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qeou_back.sv =====
// back end: cordic sine and cosine, delta quaternion and hamilton product
`default_nettype none
module qeou_back #(
  parameter int COMPONENT_WIDTH = qeou_pkg::COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STEPS    = qeou_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  qeou_pkg::fold_t                        q_data,
  input  wire logic                              q_valid,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [COMPONENT_WIDTH-1:0]      out_quat_w,
  output logic signed [COMPONENT_WIDTH-1:0]      out_quat_x,
  output logic signed [COMPONENT_WIDTH-1:0]      out_quat_y,
  output logic signed [COMPONENT_WIDTH-1:0]      out_quat_z
);
  import qeou_pkg::*;

  localparam int CW   = COMPONENT_WIDTH;
  localparam int BW   = (CW > TW) ? CW : TW;
  localparam int PW   = AMW + BW;
  localparam int SW   = PW + 2;
  localparam int STW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic signed [SW-1:0] SAT_HI = $signed((SW'(1) << (CW - 1)) - SW'(1));
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [CW-1:0] ONE_Q  = $signed(CW'(1) << (CW - 2));

  phase_t phase_r, phase_nxt;
  logic [STW-1:0] stp_r;
  logic [2:0]     k_r;

  logic signed [ZW-1:0]  x_r [3];
  logic signed [ZW-1:0]  y_r [3];
  logic signed [ZW-1:0]  z_r [3];
  logic [2:0]            flip_r;
  logic signed [TW-1:0]  cs_r [3];
  logic signed [TW-1:0]  sn_r [3];
  logic signed [PW-1:0]  prod_r [4];
  logic signed [AMW-1:0] pair_r [4];
  logic signed [PW-1:0]  t0_r [4];
  logic signed [DW-1:0]  d_r [4];
  logic signed [CW-1:0]  orient_r [4];
  logic signed [CW-1:0]  new_r [4];
  logic                  out_valid_r;
  logic signed [CW-1:0]  out_q_r [4];

  logic signed [AMW-1:0] ma [4];
  logic signed [BW-1:0]  mb [4];
  logic                  last_step, out_free, emit;
  logic signed [CW-1:0]  comp_sat;
  logic signed [DW-1:0]  d_nxt [4];

  assign last_step = (stp_r == STW'(CORDIC_STEPS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (phase_r == P_OUT) && (k_r == 3'd5) && out_free;
  assign q_pop     = (phase_r == P_IDLE) && q_valid;

  // sequencer next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      P_IDLE:   if (q_valid) phase_nxt = P_CORDIC;
      P_CORDIC: if (last_step) phase_nxt = P_ROUND;
      P_ROUND:  phase_nxt = P_PAIR;
      P_PAIR:   phase_nxt = P_TRI0;
      P_TRI0:   phase_nxt = P_TRI1;
      P_TRI1:   phase_nxt = P_DSUM;
      P_DSUM:   phase_nxt = P_OUT;
      P_OUT:    if (emit) phase_nxt = P_IDLE;
      default:  phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stp_r <= '0;
      k_r   <= '0;
    end else begin
      if (phase_r == P_IDLE) begin
        stp_r <= '0;
      end else if (phase_r == P_CORDIC) begin
        stp_r <= stp_r + STW'(1);
      end
      if (phase_r == P_DSUM) begin
        k_r <= '0;
      end else if (phase_r == P_OUT && k_r != 3'd5) begin
        k_r <= k_r + 3'd1;
      end
    end
  end

  // cordic lanes, one rotation per cycle
  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (q_pop) begin
        x_r[l]    <= CORDIC_GAIN;
        y_r[l]    <= '0;
        z_r[l]    <= $signed(q_data.z[l]);
        flip_r[l] <= q_data.flip[l];
      end else if (phase_r == P_CORDIC) begin
        if (!z_r[l][ZW-1]) begin
          x_r[l] <= x_r[l] - (y_r[l] >>> stp_r);
          y_r[l] <= y_r[l] + (x_r[l] >>> stp_r);
          z_r[l] <= z_r[l] - atan_q32(5'(stp_r));
        end else begin
          x_r[l] <= x_r[l] + (y_r[l] >>> stp_r);
          y_r[l] <= y_r[l] - (x_r[l] >>> stp_r);
          z_r[l] <= z_r[l] + atan_q32(5'(stp_r));
        end
      end
    end
  end

  // round to Q.20 and undo the fold
  always_ff @(posedge clk) begin
    logic signed [ZW-1:0] xr, yr;
    logic signed [TW-1:0] c, s;
    for (int l = 0; l < 3; l++) begin
      xr = (x_r[l] + ZW'(1 << (SC_SHIFT - 1))) >>> SC_SHIFT;
      yr = (y_r[l] + ZW'(1 << (SC_SHIFT - 1))) >>> SC_SHIFT;
      c  = xr[TW-1:0];
      s  = yr[TW-1:0];
      if (phase_r == P_ROUND) begin
        cs_r[l] <= flip_r[l] ? -c : c;
        sn_r[l] <= flip_r[l] ? -s : s;
      end
    end
  end

  // multiplier operand selection
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ma[j] = '0;
      mb[j] = '0;
    end
    case (phase_r)
      P_PAIR: begin
        ma[0] = AMW'(cs_r[0]); mb[0] = BW'(cs_r[1]);
        ma[1] = AMW'(sn_r[0]); mb[1] = BW'(sn_r[1]);
        ma[2] = AMW'(sn_r[0]); mb[2] = BW'(cs_r[1]);
        ma[3] = AMW'(cs_r[0]); mb[3] = BW'(sn_r[1]);
      end
      P_TRI0: begin
        for (int j = 0; j < 4; j++) begin
          ma[j] = prod_r[j][AMW-1:0];
          mb[j] = (j % 2 == 0) ? BW'(cs_r[2]) : BW'(sn_r[2]);
        end
      end
      P_TRI1: begin
        for (int j = 0; j < 4; j++) begin
          ma[j] = pair_r[j];
          mb[j] = (j % 2 == 0) ? BW'(sn_r[2]) : BW'(cs_r[2]);
        end
      end
      P_OUT: begin
        for (int j = 0; j < 4; j++) begin
          ma[j] = AMW'(d_r[j]);
          mb[j] = BW'(orient_r[k_r[1:0] ^ 2'(j)]);
        end
      end
      default: begin
      end
    endcase
  end

  // four multiplier lanes, registered
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      prod_r[j] <= PW'(ma[j]) * PW'(mb[j]);
    end
  end

  // keep pair products and first triple products
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (phase_r == P_TRI0) begin
        pair_r[j] <= prod_r[j][AMW-1:0];
      end
      if (phase_r == P_TRI1) begin
        t0_r[j] <= prod_r[j];
      end
    end
  end

  // delta quaternion sums, rounded to Q.28
  always_comb begin
    logic signed [PW:0] s [4];
    logic signed [PW:0] r;
    s[0] = (PW+1)'(t0_r[0]) + (PW+1)'(t0_r[1]);
    s[1] = (PW+1)'(t0_r[2]) - (PW+1)'(t0_r[3]);
    s[2] = (PW+1)'(prod_r[3]) + (PW+1)'(prod_r[2]);
    s[3] = (PW+1)'(prod_r[0]) - (PW+1)'(prod_r[1]);
    for (int j = 0; j < 4; j++) begin
      r        = (s[j] + (PW+1)'(64'd1 << (DELTA_SHIFT - 1))) >>> DELTA_SHIFT;
      d_nxt[j] = r[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == P_DSUM) begin
      for (int j = 0; j < 4; j++) begin
        d_r[j] <= d_nxt[j];
      end
    end
  end

  // hamilton product accumulate, round and saturate
  always_comb begin
    logic signed [SW-1:0] acc, r;
    logic [3:0]           neg;
    neg = neg_mask(2'(k_r - 3'd1));
    acc = '0;
    for (int j = 0; j < 4; j++) begin
      acc = neg[j] ? acc - SW'(prod_r[j]) : acc + SW'(prod_r[j]);
    end
    r = (acc + SW'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (r > SAT_HI) begin
      comp_sat = SAT_HI[CW-1:0];
    end else if (r < SAT_LO) begin
      comp_sat = SAT_LO[CW-1:0];
    end else begin
      comp_sat = r[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == P_OUT && k_r != 3'd0 && k_r != 3'd5) begin
      new_r[2'(k_r - 3'd1)] <= comp_sat;
    end
  end

  // orientation state, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r[0] <= ONE_Q;
      orient_r[1] <= '0;
      orient_r[2] <= '0;
      orient_r[3] <= '0;
    end else if (emit) begin
      for (int j = 0; j < 4; j++) begin
        orient_r[j] <= new_r[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int j = 0; j < 4; j++) begin
        out_q_r[j] <= new_r[j];
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = out_q_r[0];
  assign out_quat_x = out_q_r[1];
  assign out_quat_y = out_q_r[2];
  assign out_quat_z = out_q_r[3];

endmodule
`default_nettype wire

// ===== rtl/quaternion_euler_orientation_update_unit.sv =====
// a transaction passes the queue and then the back end phases cordic, round, pair, tri0, tri1,
// dsum and out; the back end takes a new transaction only when idle, so the iterative cordic loop
// and the four-lane multiplier sequence set the rate, and an output stall can hold it; a two-entry queue absorbs input
// reset: synchronous active-low, queue and output empty, orientation back to identity
// top level of the quaternion euler orientation update unit
`default_nettype none
module quaternion_euler_orientation_update_unit #(
  parameter int ANGLE_WIDTH     = qeou_pkg::ANGLE_WIDTH_DEF,
  parameter int COMPONENT_WIDTH = qeou_pkg::COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STEPS    = qeou_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ANGLE_WIDTH-1:0]       in_angle_x,
  input  wire logic [ANGLE_WIDTH-1:0]       in_angle_y,
  input  wire logic [ANGLE_WIDTH-1:0]       in_angle_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [COMPONENT_WIDTH-1:0] out_quat_w,
  output logic signed [COMPONENT_WIDTH-1:0] out_quat_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_quat_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_quat_z
);
  import qeou_pkg::*;

  fold_t  fold, q_data;
  qstat_t q_stat;
  logic   q_pop;

  assign in_stall = q_stat.full;

  // classify and fold the incoming transaction
  qeou_front #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_front (
    .in_angle_x (in_angle_x),
    .in_angle_y (in_angle_y),
    .in_angle_z (in_angle_z),
    .fold       (fold)
  );

  // decoupling queue
  qeou_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (fold),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  // rotation and product engine
  qeou_back #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_valid    (!q_stat.empty),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_quat_w (out_quat_w),
    .out_quat_x (out_quat_x),
    .out_quat_y (out_quat_y),
    .out_quat_z (out_quat_z)
  );

endmodule
`default_nettype wire
